// ----- design/wfu_pkg.sv -----
// ----------------------------------------------------------------------------
// wfu_pkg: waveform frame unpacker shared definitions
// Frame geometry, field widths, result codes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wfu_pkg;

  // Samples carried in one frame; two samples share each group of three bytes.
  localparam int SAMPLE_COUNT = 1024;
  localparam int GROUP_COUNT  = SAMPLE_COUNT / 2;
  localparam int GROUP_W      = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 10;
  localparam int SAMPLE_W = 12;
  localparam int FREQ_W   = 24;

  // Sample index before it is wrapped to the memory address width.
  localparam int ADDR_EXT_W = (GROUP_W + 1 > ADDR_W) ? GROUP_W + 1 : ADDR_W;

  localparam logic [BYTE_W-1:0] ACK_CHAR = 8'd101;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_FREQ   = 1'b1
  } kind_t;

  // Position of a byte within its three-byte group.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t                kind;
    logic [ADDR_W-1:0]    mem_address;
    logic [SAMPLE_W-1:0]  sample_value;
    logic [FREQ_W-1:0]    tuning_word;
    logic [BYTE_W-1:0]    ack_byte;
  } result_t;

endpackage

// ----- design/wfu_if.sv -----
// ----------------------------------------------------------------------------
// wfu_if: waveform frame unpacker channel interfaces
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wfu_byte_if;
  logic                      valid;
  logic                      ready;
  logic [wfu_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wfu_result_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [wfu_pkg::ADDR_W-1:0]   mem_address;
  logic [wfu_pkg::SAMPLE_W-1:0] sample_value;
  logic [wfu_pkg::FREQ_W-1:0]   tuning_word;
  logic [wfu_pkg::BYTE_W-1:0]   ack_byte;

  modport source (output valid, output kind, output mem_address, output sample_value,
                  output tuning_word, output ack_byte, input ready);
  modport sink   (input valid, input kind, input mem_address, input sample_value,
                  input tuning_word, input ack_byte, output ready);
endinterface

// ----- design/waveform_frame_unpacker.sv -----
// ----------------------------------------------------------------------------
// waveform_frame_unpacker: packed 12-bit sample frame unpacker
// Turns a byte stream into waveform memory writes and a frequency word.
// ----------------------------------------------------------------------------
//   channel   direction  fields
//   byte_in   in         rx_byte[7:0]
//   result    out        kind, mem_address[9:0], sample_value[11:0],
//                        tuning_word[23:0], ack_byte[7:0]
//
// One byte is accepted per cycle while the result register is free; a result
// passes from its byte through the input register and then the result register.
// Reset (rst, synchronous) empties both registers and returns to frame start.
// A stalled result holds its beat; input keeps flowing while the result
// register can still be freed in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module waveform_frame_unpacker (
  input  logic         clk,
  input  logic         rst,
  wfu_byte_if.sink     byte_in,
  wfu_result_if.source result
);
  import wfu_pkg::*;

  logic               held_valid;
  logic [BYTE_W-1:0]  held_byte;
  logic               out_free;
  logic               advance;
  logic               emit;
  result_t            decoded;

  // The held byte moves on as soon as the result register can take its outcome.
  assign advance = held_valid && out_free;

  wfu_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  wfu_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (held_byte),
    .emit    (emit),
    .result  (decoded)
  );

  wfu_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .emit      (emit),
    .result_in (decoded),
    .free      (out_free),
    .result    (result)
  );

endmodule

// ----- design/wfu_in_stage.sv -----
// ----------------------------------------------------------------------------
// wfu_in_stage: input register
// Captures one byte beat and holds it until the decoder consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wfu_in_stage (
  input  logic                       clk,
  input  logic                       rst,
  wfu_byte_if.sink                   byte_in,
  input  logic                       advance,
  output logic                       held_valid,
  output logic [wfu_pkg::BYTE_W-1:0] held_byte
);
  import wfu_pkg::*;

  // A new beat may enter when the register is empty or the held one leaves in the same cycle.
  assign byte_in.ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_in.ready) begin
      held_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      held_byte <= byte_in.rx_byte;
    end
  end

endmodule

// ----- design/wfu_decode.sv -----
// ----------------------------------------------------------------------------
// wfu_decode: frame position tracking and result formation
// Tracks group phase, sample group and frame section, and builds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wfu_decode (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [wfu_pkg::BYTE_W-1:0] rx_byte,
  output logic                       emit,
  output wfu_pkg::result_t           result
);
  import wfu_pkg::*;

  phase_t               phase;
  phase_t               phase_next;
  logic [GROUP_W-1:0]   group;
  logic [GROUP_W-1:0]   group_next;
  logic                 in_freq;
  logic                 in_freq_next;
  logic [BYTE_W-1:0]    held_first;
  logic [BYTE_W-1:0]    held_second;
  logic [ADDR_EXT_W-1:0] addr_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FIRST;
      group       <= '0;
      in_freq     <= 1'b0;
      held_first  <= '0;
      held_second <= '0;
    end else if (step) begin
      phase   <= phase_next;
      group   <= group_next;
      in_freq <= in_freq_next;
      if (phase == PH_FIRST) begin
        held_first <= rx_byte;
      end
      if (phase == PH_SECOND) begin
        held_second <= rx_byte;
      end
    end
  end

  // Next position within the frame.
  always_comb begin
    phase_next   = phase;
    group_next   = group;
    in_freq_next = in_freq;
    unique case (phase)
      PH_FIRST:  phase_next = PH_SECOND;
      PH_SECOND: phase_next = PH_THIRD;
      PH_THIRD: begin
        phase_next = PH_FIRST;
        if (in_freq) begin
          in_freq_next = 1'b0;
        end else if (group == GROUP_W'(GROUP_COUNT - 1)) begin
          group_next   = '0;
          in_freq_next = 1'b1;
        end else begin
          group_next = group + 1'b1;
        end
      end
      default: phase_next = PH_FIRST;
    endcase
  end

  // Sample A sits at the even address of its group, sample B at the odd one.
  assign addr_ext = ADDR_EXT_W'({group, phase == PH_THIRD});

  always_comb begin
    emit   = 1'b0;
    result = '0;
    result.kind = KIND_SAMPLE;
    unique case (phase)
      PH_FIRST: emit = 1'b0;
      PH_SECOND: begin
        emit                = step && !in_freq;
        result.mem_address  = addr_ext[ADDR_W-1:0];
        result.sample_value = {held_first, rx_byte[7:4]};
      end
      PH_THIRD: begin
        emit = step;
        if (in_freq) begin
          result.kind        = KIND_FREQ;
          result.tuning_word = {held_first, held_second, rx_byte};
          result.ack_byte    = ACK_CHAR;
        end else begin
          result.mem_address  = addr_ext[ADDR_W-1:0];
          result.sample_value = {held_second[3:0], rx_byte};
        end
      end
      default: emit = 1'b0;
    endcase
  end

`ifndef SYNTHESIS
  // The frequency word is always the tail of a frame, and the next frame starts clean.
  a_restart_after_freq: assert property (@(posedge clk) disable iff (rst)
    emit && result.kind == KIND_FREQ |=> !in_freq && phase == PH_FIRST && group == '0)
    else $error("frame did not restart after frequency word");

  a_freq_group_zero: assert property (@(posedge clk) disable iff (rst)
    in_freq |-> group == '0)
    else $error("group counter not cleared during frequency word");

  a_first_byte_silent: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_FIRST |-> !emit)
    else $error("result produced on first byte of a group");
`endif

endmodule

// ----- design/wfu_out_stage.sv -----
// ----------------------------------------------------------------------------
// wfu_out_stage: result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wfu_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             emit,
  input  wfu_pkg::result_t result_in,
  output logic             free,
  wfu_result_if.source     result
);
  import wfu_pkg::*;

  result_t data;

  assign free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= emit;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      data <= result_in;
    end
  end

  assign result.kind         = data.kind;
  assign result.mem_address  = data.mem_address;
  assign result.sample_value = data.sample_value;
  assign result.tuning_word  = data.tuning_word;
  assign result.ack_byte     = data.ack_byte;

endmodule
